// ----- rtl/core/stbs_pkg.sv -----
package stbs_pkg;

  // Default sizing of the key table
  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned KEY_WIDTH_DEF   = 32;

  // Command codes carried on in_cmd
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_PROBE
  } state_t;

endpackage

// ----- rtl/core/stbs_ram.sv -----
module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, read data registered, read-before-write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/sorted_table_binary_search_unit.sv -----
// Write transaction: on acceptance, acknowledge strobes on out_valid the next cycle.
// Search transaction: a setup step on acceptance, then up to log2(TABLE_DEPTH)+1
//   probes, each a registered key RAM read followed by a signed compare. An empty range
//   answers in the cycle after acceptance. busy stays high until the result strobe.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid; the
//   key table is not cleared. Results strobe for one cycle and cannot be stalled.
module sorted_table_binary_search_unit #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_WIDTH   = stbs_pkg::KEY_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,

  // command side
  input  logic               start,
  output logic               busy,
  input  logic               in_cmd,
  input  logic [7:0]         in_entry_index,
  input  logic signed [31:0] in_entry_key,
  input  logic signed [31:0] in_target_key,
  input  logic [7:0]         in_range_low,
  input  logic signed [8:0]  in_range_high,

  // result side
  output logic               out_valid,
  output logic               out_found,
  output logic [7:0]         out_position
);

  // AW: RAM address bits. IW: bits for any table position or 8-bit index.
  // SW: signed search bounds, room for lo+hi and for hi = mid-1 = -1.
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IW = (AW > 8) ? AW : 8;
  localparam int SW = IW + 2;

  localparam logic signed [SW-1:0] HI_MAX = SW'(TABLE_DEPTH - 1);

  // ---------------------------------------------------------------------------
  // Key normalization: keys are sign-extended from 32 bits, then cut to
  // KEY_WIDTH bits. The compare below is signed on KEY_WIDTH bits.
  // ---------------------------------------------------------------------------
  logic signed [63:0]          wkey_ext;
  logic signed [63:0]          tkey_ext;
  logic signed [KEY_WIDTH-1:0] wkey;
  logic signed [KEY_WIDTH-1:0] tkey;

  assign wkey_ext = 64'(in_entry_key);
  assign tkey_ext = 64'(in_target_key);
  assign wkey     = wkey_ext[KEY_WIDTH-1:0];
  assign tkey     = tkey_ext[KEY_WIDTH-1:0];

  // ---------------------------------------------------------------------------
  // Write index wraps modulo the table depth. Constant lookup table, folded at
  // elaboration (identity when the table holds 256 or more entries).
  // ---------------------------------------------------------------------------
  logic [7:0]    idx_lut [256];
  logic [IW-1:0] widx;
  logic [AW-1:0] waddr;

  for (genvar g = 0; g < 256; g++) begin : g_idx_lut
    localparam int unsigned WRAP = g % TABLE_DEPTH;
    assign idx_lut[g] = 8'(WRAP);
  end

  assign widx  = IW'(idx_lut[in_entry_index]);
  assign waddr = widx[AW-1:0];

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  stbs_pkg::state_t            state_r,     state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        found_r,     found_nxt;
  logic [7:0]                  pos_r,       pos_nxt;
  logic signed [SW-1:0]        lo_r,        lo_nxt;
  logic signed [SW-1:0]        hi_r,        hi_nxt;
  logic signed [SW-1:0]        mid_r,       mid_nxt;
  logic signed [KEY_WIDTH-1:0] target_r,    target_nxt;

  // ---------------------------------------------------------------------------
  // Key table
  // ---------------------------------------------------------------------------
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [KEY_WIDTH-1:0] ram_rdata;

  stbs_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wkey),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Search range setup from the incoming transaction
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] lo0;
  logic signed [SW-1:0] hi_ext;
  logic signed [SW-1:0] hi0;
  logic signed [SW-1:0] sum0;
  logic signed [SW-1:0] mid0;

  assign lo0    = signed'(SW'(in_range_low));
  assign hi_ext = SW'(in_range_high);
  assign hi0    = (hi_ext > HI_MAX) ? HI_MAX : hi_ext;
  assign sum0   = lo0 + hi0;
  assign mid0   = sum0 >>> 1;

  // ---------------------------------------------------------------------------
  // Probe step: compare the key read at mid_r, narrow the range and form the
  // next midpoint in the same cycle.
  // ---------------------------------------------------------------------------
  logic signed [KEY_WIDTH-1:0] key_rd;
  logic                        hit;
  logic                        key_gt;
  logic signed [SW-1:0]        nlo;
  logic signed [SW-1:0]        nhi;
  logic signed [SW-1:0]        nsum;
  logic signed [SW-1:0]        nmid;

  assign key_rd = signed'(ram_rdata);
  assign hit    = (key_rd == target_r);
  assign key_gt = (key_rd > target_r);
  assign nlo    = key_gt ? lo_r : (mid_r + SW'(1));
  assign nhi    = key_gt ? (mid_r - SW'(1)) : hi_r;
  assign nsum   = nlo + nhi;
  assign nmid   = nsum >>> 1;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    found_nxt     = 1'b0;
    pos_nxt       = '0;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    target_nxt    = target_r;
    ram_we        = 1'b0;
    ram_addr      = mid_r[AW-1:0];

    unique case (state_r)
      stbs_pkg::ST_IDLE: begin
        if (start) begin
          if (in_cmd == stbs_pkg::CMD_WRITE) begin
            // store and acknowledge
            ram_we        = 1'b1;
            ram_addr      = waddr;
            out_valid_nxt = 1'b1;
          end else begin
            target_nxt = tkey;
            if (lo0 > hi0) begin
              // empty range: not found at once
              out_valid_nxt = 1'b1;
            end else begin
              ram_addr  = mid0[AW-1:0];
              lo_nxt    = lo0;
              hi_nxt    = hi0;
              mid_nxt   = mid0;
              state_nxt = stbs_pkg::ST_PROBE;
            end
          end
        end
      end

      stbs_pkg::ST_PROBE: begin
        if (hit) begin
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b1;
          pos_nxt       = mid_r[7:0];
          state_nxt     = stbs_pkg::ST_IDLE;
        end else begin
          lo_nxt = nlo;
          hi_nxt = nhi;
          if (nlo > nhi) begin
            out_valid_nxt = 1'b1;
            state_nxt     = stbs_pkg::ST_IDLE;
          end else begin
            ram_addr = nmid[AW-1:0];
            mid_nxt  = nmid;
          end
        end
      end

      default: begin
        state_nxt = stbs_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stbs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    found_r  <= found_nxt;
    pos_r    <= pos_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    target_r <= target_nxt;
  end

  assign busy         = (state_r != stbs_pkg::ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_found    = found_r;
  assign out_position = pos_r;

endmodule

// ----- sim/sorted_table_binary_search_unit_checker.sv -----
`timescale 1ns / 100ps

module sorted_table_binary_search_unit_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_cmd,
  input  logic [7:0]         in_entry_index,
  input  logic signed [31:0] in_entry_key,
  input  logic signed [31:0] in_target_key,
  input  logic [7:0]         in_range_low,
  input  logic signed [8:0]  in_range_high,
  input  logic               out_valid,
  input  logic               out_found,
  input  logic [7:0]         out_position,
  output int unsigned        fail_count,
  output int unsigned        open_count
);

  typedef struct packed {
    logic       found;
    logic [7:0] position;
  } answer_t;

  logic signed [31:0] key_shadow [256];
  answer_t            pending_answers [$];

  // Walks the probe path of one search over the shadow table.
  function automatic answer_t binary_search_outcome(logic signed [31:0] target,
                                                     logic [7:0] range_lo,
                                                     logic signed [8:0] range_hi);
    answer_t res;
    int lo;
    int hi;
    int mid;
    res = '0;
    lo = int'(range_lo);
    hi = int'(range_hi);
    if (hi > 255) hi = 255;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (key_shadow[mid[7:0]] == target) begin
        res.found = 1'b1;
        res.position = mid[7:0];
        return res;
      end
      if (key_shadow[mid[7:0]] > target) hi = mid - 1;
      else lo = mid + 1;
    end
    return res;
  endfunction

  initial begin
    fail_count = 0;
    open_count = 0;
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result found=%0d position=%0d", $time,
                   out_found, out_position);
          fail_count++;
        end else begin
          want = pending_answers.pop_front();
          if (out_found !== want.found) begin
            $display("%0t: found mismatch, expected %0d, actual %0d", $time,
                     want.found, out_found);
            fail_count++;
          end
          if (out_position !== want.position) begin
            $display("%0t: position mismatch, expected %0d, actual %0d", $time,
                     want.position, out_position);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (in_cmd == stbs_pkg::CMD_WRITE) begin
          key_shadow[in_entry_index] = in_entry_key;
          pending_answers.push_back('0);
        end else begin
          pending_answers.push_back(binary_search_outcome(in_target_key, in_range_low,
                                                          in_range_high));
        end
      end
      open_count = pending_answers.size();
    end
  end

endmodule

// ----- sim/sorted_table_binary_search_unit_tb.sv -----
`timescale 1ns / 100ps

module sorted_table_binary_search_unit_tb;

  localparam int KEY_MAX = 2147483647;
  localparam int KEY_MIN = -2147483647 - 1;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_cmd;
  logic [7:0]         in_entry_index;
  logic signed [31:0] in_entry_key;
  logic signed [31:0] in_target_key;
  logic [7:0]         in_range_low;
  logic signed [8:0]  in_range_high;
  logic               out_valid;
  logic               out_found;
  logic [7:0]         out_position;

  int unsigned fail_count;
  int unsigned open_count;

  // Image of what the table holds, only used to pick search targets
  // that hit or narrowly miss stored keys.
  logic signed [31:0] table_image [256];

  int unsigned items_sent;
  int unsigned idle_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  sorted_table_binary_search_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_entry_index(in_entry_index),
    .in_entry_key  (in_entry_key),
    .in_target_key (in_target_key),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .out_valid     (out_valid),
    .out_found     (out_found),
    .out_position  (out_position)
  );

  sorted_table_binary_search_unit_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_entry_index(in_entry_index),
    .in_entry_key  (in_entry_key),
    .in_target_key (in_target_key),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .out_valid     (out_valid),
    .out_found     (out_found),
    .out_position  (out_position),
    .fail_count    (fail_count),
    .open_count    (open_count)
  );

  // One transaction. Entered and left at a falling edge. Idle cycles
  // (start low) come first, so a following transaction with no gap keeps
  // start high across the boundary.
  task automatic send_item(input logic cmd, input logic [7:0] idx,
                           input logic signed [31:0] ekey, input logic signed [31:0] tkey,
                           input logic [7:0] rlo, input int rhi);
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    in_cmd         = cmd;
    in_entry_index = idx;
    in_entry_key   = ekey;
    in_target_key  = tkey;
    in_range_low   = rlo;
    in_range_high  = rhi[8:0];
    start          = 1'b1;
    // accepted at the first rising edge with busy low
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (cmd == stbs_pkg::CMD_WRITE) table_image[idx] = ekey;
    items_sent++;
  endtask

  // Unused fields of each command carry random junk so every bit toggles.
  task automatic write_entry(input int idx, input logic signed [31:0] key);
    send_item(stbs_pkg::CMD_WRITE, idx[7:0], key, $urandom(), 8'($urandom()),
              $urandom_range(0, 511) - 256);
  endtask

  task automatic search_range(input logic signed [31:0] target, input int lo, input int hi);
    send_item(stbs_pkg::CMD_SEARCH, 8'($urandom()), $urandom(), target, lo[7:0], hi);
  endtask

  // Target for a search over lo..hi: mostly stored keys, then near misses,
  // random keys and the key extremes.
  function automatic logic signed [31:0] pick_target(input int lo, input int hi);
    int pos;
    int sel;
    pos = (hi >= lo) ? $urandom_range(lo, hi) : lo;
    sel = $urandom_range(0, 99);
    if (sel < 50) return table_image[pos[7:0]];
    if (sel < 70) return $urandom_range(0, 1) ? table_image[pos[7:0]] + 1
                                              : table_image[pos[7:0]] - 1;
    if (sel < 85) return $urandom();
    return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
  endfunction

  // Well-formed sequence: fill base..base+len-1 with ascending keys, then
  // search sub-ranges of it. Probes never leave the written region.
  task automatic sorted_region(input int base, input int len);
    longint key;
    longint stride;
    int lo;
    int hi;
    int n;
    case ($urandom_range(0, 3))
      0: key = longint'(KEY_MIN) + $urandom_range(0, 1000);
      1: key = longint'(KEY_MAX) - $urandom_range(0, 2000);
      default: key = longint'($signed($urandom()));
    endcase
    case ($urandom_range(0, 2))
      0: stride = 2;        // duplicates likely
      1: stride = 1000;
      default: stride = 1 << 24;
    endcase
    for (int i = 0; i < len; i++) begin
      if (key > KEY_MAX) key = KEY_MAX;
      write_entry(base + i, key[31:0]);
      key += $urandom_range(0, stride);
    end
    n = 2 + $urandom_range(0, 6);
    repeat (n) begin
      lo = base + $urandom_range(0, len - 1);
      if ($urandom_range(0, 9) == 0) hi = lo - 1;
      else hi = lo + $urandom_range(0, base + len - 1 - lo);
      search_range(pick_target(lo, hi), lo, hi);
    end
  endtask

  // Noise: stray writes that break the ordering, and searches over any
  // range, empty and negative ones included. Only run once the whole table
  // has been written.
  task automatic noise_burst();
    int lo;
    int hi;
    repeat ($urandom_range(2, 8)) begin
      if ($urandom_range(0, 1)) begin
        write_entry($urandom_range(0, 255), $urandom());
      end else begin
        lo = $urandom_range(0, 255);
        hi = $urandom_range(0, 511) - 256;
        search_range(pick_target(lo, (hi > lo) ? hi : lo), lo, hi);
      end
    end
  endtask

  initial begin
    int seq;
    int len;
    int pct_by_phase [3];
    pct_by_phase = '{0, 74, 31};
    rst_n          = 1'b0;
    start          = 1'b0;
    in_cmd         = stbs_pkg::CMD_WRITE;
    in_entry_index = '0;
    in_entry_key   = '0;
    in_target_key  = '0;
    in_range_low   = '0;
    in_range_high  = '0;
    items_sent     = 0;
    idle_pct       = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // ---- directed ----
    write_entry(0, KEY_MIN);
    write_entry(255, KEY_MAX);
    write_entry(128, 0);
    write_entry(127, -5);
    write_entry(129, 7);
    search_range(KEY_MIN, 0, 0);          // lowest slot, lowest key
    search_range(KEY_MAX, 255, 255);      // top slot, top key
    search_range(0, 127, 129);            // hit on first probe
    search_range(-5, 127, 129);           // hi moves down, then hit
    search_range(7, 127, 129);            // lo moves up, then hit
    search_range(3, 127, 129);            // miss between keys
    search_range(-100, 127, 129);         // miss below range
    search_range(KEY_MAX, 0, 0);          // single entry, miss
    // empty ranges: no probe at all
    search_range(0, 10, -1);
    search_range(0, 0, -256);
    search_range(KEY_MIN, 200, 100);
    search_range(KEY_MAX, 255, 254);
    // unsorted: key present at 130 but the path never gets there; then key 8 at 130 is found
    write_entry(130, -50);
    search_range(-50, 128, 130);
    write_entry(130, 8);
    search_range(8, 128, 130);

    // ---- random ----
    // Whole-table ascending fill first, so later noise searches only read
    // written entries.
    sorted_region(0, 256);
    seq = 0;
    while (items_sent < 1225) begin
      // phases: no idling, heavy idling, moderate idling
      idle_pct = pct_by_phase[(seq / 3) % 3];
      if ($urandom_range(0, 99) < 20) begin
        noise_burst();
      end else begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) : $urandom_range(1, 256);
        sorted_region($urandom_range(0, 256 - len), len);
      end
      seq++;
    end

    // ---- drain ----
    start = 1'b0;
    while (open_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (about 1300 transactions,
  // each a full search plus a long idle stretch).
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
